// ===== hdl/ted_pkg.sv =====
// ---------------------------------------------------------------------------
// ted_pkg: shared constants, types and helpers of the tape echo delay line
// Widths, memory geometry, register map and saturation functions.
// ---------------------------------------------------------------------------
package ted_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int STATE_W    = SAMPLE_W + 8;
  localparam int MAX_DELAY  = 131072;
  localparam int POS_W      = $clog2(MAX_DELAY);
  localparam int CHANNELS   = 2;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int MEM_DEPTH  = CHANNELS * MAX_DELAY;
  localparam int MEM_AW     = CH_W + POS_W;

  localparam int GAIN_W     = 16;
  localparam int HP_COEF    = 197;
  localparam int HP_SHIFT   = 16;
  localparam int GAIN_SHIFT = 23;

  localparam int MUL_A_W    = STATE_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [1:0] REG_WET_GAIN      = 2'd2;

  localparam logic [POS_W-1:0]  DELAY_RESET = POS_W'(7200);
  localparam logic [GAIN_W-1:0] FB_RESET    = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] WET_RESET   = GAIN_W'(32768);

  typedef struct packed {
    logic [POS_W-1:0]  delay_length;
    logic [GAIN_W-1:0] feedback_gain;
    logic [GAIN_W-1:0] wet_gain;
  } cfg_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd1 <<< (STATE_W - 1);
    hi = hi - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) begin
      return hi[STATE_W-1:0];
    end else if (v < lo) begin
      return lo[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd1 <<< (SAMPLE_W - 1);
    hi = hi - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== hdl/ted_if.sv =====
// ---------------------------------------------------------------------------
// ted_if: sample stream channels
// Valid/ready channels for the dry input and the processed output.
// ---------------------------------------------------------------------------
interface ted_in_if;
  import ted_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface ted_out_if;
  import ted_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hdl/tape_echo_delay_line.sv =====
// ---------------------------------------------------------------------------
// tape_echo_delay_line: feedback delay-line echo
// Per-channel delay memory, high-pass and low-pass in the loop, wet/dry mix.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one dry sample and its channel index per transfer; out_o
//   returns one processed sample per input, in order. Registers are written
//   over the APB-style port, only while the block is idle; the user must
//   keep to this, the block does not enforce it. A sample is taken only when
//   the sequencer is idle: the next sample waits until the previous one has
//   passed its last step, which needs a free output register. The steps
//   (read, high-pass, low-pass, feedback, wet) are built around the single
//   shared multiplier (high-pass coefficient, feedback gain, wet gain) and
//   the one port of the delay memory (read, then write back).
//   The result sits in an output register; if the receiver stalls, the
//   next sample is accepted and processed, and only its last step waits
//   until the register is free.
//   Reset clears channel state and loads register defaults. The delay memory
//   needs no clearing pass: each channel tracks whether its write position
//   has wrapped, and slots not yet written read as zero.
// ---------------------------------------------------------------------------
module tape_echo_delay_line (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ted_in_if.sink                     in_i,
  ted_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ted_pkg::APB_AW-1:0] paddr,
  input  logic [ted_pkg::APB_DW-1:0] pwdata,
  output logic [ted_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import ted_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_HP_MUL, ST_HP_UPD, ST_HP_OUT,
    ST_LP_UPD, ST_FB_MUL, ST_FB_WR, ST_WET
  } state_e;

  state_e                      state_q;
  cfg_t                        cfg;

  logic [POS_W-1:0]            wp_q      [CHANNELS];
  logic                        wrapped_q [CHANNELS];
  logic signed [STATE_W-1:0]   hs_q      [CHANNELS];
  logic signed [STATE_W-1:0]   ls_q      [CHANNELS];

  logic [CH_W-1:0]             ch_q;
  logic [POS_W-1:0]            pos_q;
  logic signed [SAMPLE_W-1:0]  x_q;
  logic                        hit_q;
  logic signed [STATE_W-1:0]   xs_q;
  logic signed [STATE_W-1:0]   hp_q;
  logic signed [SAMPLE_W-1:0]  stored_q;
  logic                        out_valid_q;
  logic signed [SAMPLE_W-1:0]  out_data_q;

  logic [POS_W-1:0]            wp_in;
  logic [POS_W-1:0]            rd_pos;
  logic                        rd_hit;
  logic                        in_xfer;

  logic                        ram_we;
  logic [MEM_AW-1:0]           ram_addr;
  logic [SAMPLE_W-1:0]         ram_rdata;

  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]   mul_p;

  logic signed [STATE_W-1:0]   h_cur;
  logic signed [STATE_W-1:0]   l_cur;
  logic signed [MUL_P_W-1:0]   hp_rnd;
  logic signed [MUL_P_W-1:0]   gain_rnd;
  logic signed [31:0]          lp_diff;
  logic signed [31:0]          lp_step;
  logic signed [STATE_W-1:0]   h_new;
  logic signed [STATE_W-1:0]   hp_new;
  logic signed [STATE_W-1:0]   l_new;
  logic signed [SAMPLE_W-1:0]  gain_out;
  logic                        out_free;

  ted_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ted_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (stored_q),
    .rdata_o (ram_rdata)
  );

  ted_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Read slot sits delay_length behind the write position; it holds data
  // only if it was written since reset.
  assign wp_in  = wp_q[in_i.channel];
  assign rd_pos = wp_in - cfg.delay_length;
  assign rd_hit = wrapped_q[in_i.channel] || (rd_pos < wp_in);

  assign ram_we   = (state_q == ST_WET);
  assign ram_addr = (state_q == ST_IDLE) ? {in_i.channel, rd_pos} : {ch_q, pos_q};

  assign h_cur = hs_q[ch_q];
  assign l_cur = ls_q[ch_q];

  always_comb begin
    case (state_q)
      ST_HP_MUL: begin
        mul_a = MUL_A_W'(xs_q) - MUL_A_W'(h_cur);
        mul_b = MUL_B_W'(HP_COEF);
      end
      ST_FB_MUL: begin
        mul_a = MUL_A_W'(l_cur);
        mul_b = $signed({1'b0, cfg.feedback_gain});
      end
      default: begin
        mul_a = MUL_A_W'(l_cur);
        mul_b = $signed({1'b0, cfg.wet_gain});
      end
    endcase
  end

  // Rounding shifts add half an LSB and floor.
  assign hp_rnd   = (mul_p + MUL_P_W'(1 << (HP_SHIFT - 1))) >>> HP_SHIFT;
  assign gain_rnd = (mul_p + MUL_P_W'(1 << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
  assign h_new    = sat_state(32'(h_cur) + $signed(hp_rnd[31:0]));
  assign hp_new   = sat_state(32'(xs_q) - 32'(h_cur));
  assign lp_diff  = 32'(hp_q) - 32'(l_cur);
  assign lp_step  = (lp_diff + 32'sd2) >>> 2;
  assign l_new    = sat_state(32'(l_cur) + lp_step);
  assign gain_out = sat_sample(32'(x_q) + $signed(gain_rnd[31:0]));
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      ch_q        <= '0;
      pos_q       <= '0;
      x_q         <= '0;
      hit_q       <= 1'b0;
      xs_q        <= '0;
      hp_q        <= '0;
      stored_q    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]      <= '0;
        wrapped_q[c] <= 1'b0;
        hs_q[c]      <= '0;
        ls_q[c]      <= '0;
      end
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_WET)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            ch_q    <= in_i.channel;
            pos_q   <= wp_in;
            x_q     <= in_i.sample_in;
            hit_q   <= rd_hit;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          xs_q    <= hit_q ? $signed({ram_rdata[SAMPLE_W-1], ram_rdata, 7'b0}) : '0;
          state_q <= ST_HP_MUL;
        end
        ST_HP_MUL: begin
          state_q <= ST_HP_UPD;
        end
        ST_HP_UPD: begin
          hs_q[ch_q] <= h_new;
          state_q    <= ST_HP_OUT;
        end
        ST_HP_OUT: begin
          hp_q    <= hp_new;
          state_q <= ST_LP_UPD;
        end
        ST_LP_UPD: begin
          ls_q[ch_q] <= l_new;
          state_q    <= ST_FB_MUL;
        end
        ST_FB_MUL: begin
          state_q <= ST_FB_WR;
        end
        ST_FB_WR: begin
          // Feedback product is ready; the wet product starts this cycle.
          stored_q <= gain_out;
          state_q  <= ST_WET;
        end
        ST_WET: begin
          // While the output register is still full and not taken, it holds.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= gain_out;
            wp_q[ch_q]  <= pos_q + POS_W'(1);
            if (pos_q == POS_W'(MAX_DELAY - 1)) begin
              wrapped_q[ch_q] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

// ===== hdl/ted_ram.sv =====
// ---------------------------------------------------------------------------
// ted_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ---------------------------------------------------------------------------
module ted_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ted_mul.sv =====
// ---------------------------------------------------------------------------
// ted_mul: shared signed multiplier
// Serves the high-pass coefficient and both gain products; product registered.
// ---------------------------------------------------------------------------
module ted_mul (
  input  logic                              clk_i,
  input  logic signed [ted_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [ted_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ted_pkg::MUL_P_W-1:0] p_o
);
  import ted_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== hdl/ted_cfg.sv =====
// ---------------------------------------------------------------------------
// ted_cfg: configuration registers
// APB-style register file holding delay length and the two gains.
// ---------------------------------------------------------------------------
module ted_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ted_pkg::APB_AW-1:0]   paddr,
  input  logic [ted_pkg::APB_DW-1:0]   pwdata,
  output logic [ted_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output ted_pkg::cfg_t                cfg_o
);
  import ted_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_length  <= DELAY_RESET;
      cfg_q.feedback_gain <= FB_RESET;
      cfg_q.wet_gain      <= WET_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DELAY_LENGTH:  cfg_q.delay_length  <= pwdata[POS_W-1:0];
        REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= pwdata[GAIN_W-1:0];
        REG_WET_GAIN:      cfg_q.wet_gain      <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DELAY_LENGTH:  prdata = APB_DW'(cfg_q.delay_length);
      REG_FEEDBACK_GAIN: prdata = APB_DW'(cfg_q.feedback_gain);
      REG_WET_GAIN:      prdata = APB_DW'(cfg_q.wet_gain);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sim/tape_echo_delay_line_test.sv =====
// ---------------------------------------------------------------------------
// tape_echo_delay_line_test: self-checking bench for the tape echo delay line
// Drives dry samples and register writes, predicts every processed sample
// with a bit-exact model of the echo loop, and compares each output transfer
// in order. A short table of directed rows comes first, then random segments
// with random register settings under several patterns of idling and stalls.
// ---------------------------------------------------------------------------
module tape_echo_delay_line_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ted_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int N_DIRECTED = 27;
  localparam int N_PHASES = 4;
  localparam int SEGMENTS = 5;
  localparam int SEG_SAMPLES = 92;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    logic [1:0]                 reg_idx;
    logic [APB_DW-1:0]          wdata;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] dry;
    bit                         has_exp;
    logic signed [SAMPLE_W-1:0] wet_out;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ted_in_if  in_ch ();
  ted_out_if out_ch ();

  tape_echo_delay_line u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the echo state: registers, per-channel filters and positions,
  // and the delay memory, where a slot never written reads as zero.
  cfg_t                       echo_cfg;
  int unsigned                wr_pos [CHANNELS];
  longint                     hp_state [CHANNELS];
  longint                     lp_state [CHANNELS];
  logic signed [SAMPLE_W-1:0] echo_mem [int unsigned];

  logic signed [SAMPLE_W-1:0] expected_out [$];
  int                         mismatch_count;
  int                         send_idle_pct;
  int                         recv_stall_pct;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh7FFF, 1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh8000, 1'b1, 16'sh8000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'sh0000, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'shFFFF, 1'b1, 16'shFFFF},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh5555, 1'b1, 16'sh5555},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'shAAAA, 1'b1, 16'shAAAA},
    '{ROW_WRITE, REG_DELAY_LENGTH, 32'd1, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_FEEDBACK_GAIN, 32'd62259, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_WET_GAIN, 32'd65535, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'sh0001, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_FEEDBACK_GAIN, 32'hFFFF_FFFF, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh1234, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'shEDCB, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_DELAY_LENGTH, 32'hFFFF_FFFF, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b1, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_UNUSED, 32'd5, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_WRITE, REG_WET_GAIN, 32'd0, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_DELAY_LENGTH, 32'd0, 1'b0, 16'sh4000, 1'b1, 16'sh4000}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Arithmetic shift right with rounding half up.
  function automatic longint rnd_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] echo_predict(
      input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] dry);
    int unsigned wp;
    int unsigned dly;
    int unsigned rd_key;
    longint tap;
    longint h;
    longint hp;
    longint l;
    longint stored;
    longint wet;
    wp = wr_pos[ch];
    dly = int'(echo_cfg.delay_length) % MAX_DELAY;
    rd_key = ch * MAX_DELAY + ((wp >= dly) ? (wp - dly) : (wp + MAX_DELAY - dly));
    tap = echo_mem.exists(rd_key) ? longint'(echo_mem[rd_key]) * 128 : 0;
    h = hp_state[ch];
    h = clamp(h + rnd_shr((tap - h) * HP_COEF, HP_SHIFT), STATE_W);
    hp_state[ch] = h;
    hp = clamp(tap - h, STATE_W);
    l = lp_state[ch];
    l = clamp(l + rnd_shr(hp - l, 2), STATE_W);
    lp_state[ch] = l;
    stored = clamp(longint'(dry) + rnd_shr(l * longint'(echo_cfg.feedback_gain), GAIN_SHIFT),
                   SAMPLE_W);
    echo_mem[ch * MAX_DELAY + wp] = stored[SAMPLE_W-1:0];
    wet = clamp(longint'(dry) + rnd_shr(l * longint'(echo_cfg.wet_gain), GAIN_SHIFT), SAMPLE_W);
    wr_pos[ch] = (wp + 1) % MAX_DELAY;
    return wet[SAMPLE_W-1:0];
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_DELAY_LENGTH:  return APB_DW'(echo_cfg.delay_length);
      REG_FEEDBACK_GAIN: return APB_DW'(echo_cfg.feedback_gain);
      REG_WET_GAIN:      return APB_DW'(echo_cfg.wet_gain);
      default:           return '0;
    endcase
  endfunction

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return SAMPLE_W'(int'($urandom_range(512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic read_reg(input logic [1:0] idx);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== reg_value(idx)) begin
      note_error($sformatf("register %0d read: expected %0d, got %0d",
                           idx, reg_value(idx), got));
    end
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DELAY_LENGTH:  echo_cfg.delay_length = data[POS_W-1:0];
      REG_FEEDBACK_GAIN: echo_cfg.feedback_gain = data[GAIN_W-1:0];
      REG_WET_GAIN:      echo_cfg.wet_gain = data[GAIN_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      read_reg(idx);
    end
  endtask

  // Holds the input off until every predicted sample has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_out.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] dry,
                             input bit has_exp, input logic signed [SAMPLE_W-1:0] wet_out);
    logic signed [SAMPLE_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.channel   <= ch;
    in_ch.sample_in <= dry;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = echo_predict(ch, dry);
    expected_out.push_back(has_exp ? wet_out : predicted);
  endtask

  task automatic random_settings();
    logic [POS_W-1:0]  dly;
    logic [GAIN_W-1:0] fb;
    logic [GAIN_W-1:0] wet;
    // Short delays dominate so that the echo actually comes around.
    case ($urandom_range(9))
      0:       dly = '0;
      1:       dly = '1;
      2, 3:    dly = POS_W'($urandom_range(4096, 65));
      default: dly = POS_W'($urandom_range(64, 1));
    endcase
    case ($urandom_range(5))
      0:       fb = '0;
      1:       fb = GAIN_W'(62259);
      2:       fb = '1;
      default: fb = GAIN_W'($urandom_range(62259));
    endcase
    case ($urandom_range(4))
      0:       wet = '0;
      1:       wet = '1;
      default: wet = GAIN_W'($urandom);
    endcase
    program_reg(REG_DELAY_LENGTH, {15'($urandom), dly});
    program_reg(REG_FEEDBACK_GAIN, {16'($urandom), fb});
    program_reg(REG_WET_GAIN, {16'($urandom), wet});
  endtask

  // Output side: random stalls, and every transfer checked against the
  // oldest prediction.
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        note_error($sformatf("unexpected output transfer: sample_out %0d",
                             out_ch.sample_out));
      end else begin
        want = expected_out.pop_front();
        if (out_ch.sample_out !== want) begin
          note_error($sformatf("sample_out mismatch: expected %0d, got %0d",
                               want, out_ch.sample_out));
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    automatic int send_pcts [N_PHASES] = '{0, 48, 0, 35};
    automatic int recv_pcts [N_PHASES] = '{0, 0, 48, 35};
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.channel   = '0;
    in_ch.sample_in = '0;
    mismatch_count  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    echo_cfg        = '{delay_length: DELAY_RESET, feedback_gain: FB_RESET,
                        wet_gain: WET_RESET};
    for (int c = 0; c < CHANNELS; c++) begin
      wr_pos[c]   = 0;
      hp_state[c] = 0;
      lp_state[c] = 0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_reg(REG_DELAY_LENGTH);
    read_reg(REG_FEEDBACK_GAIN);
    read_reg(REG_WET_GAIN);

    // With memory and filters at zero, the first samples pass through dry.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        program_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
      end else begin
        send_sample(directed_rows[i].ch, directed_rows[i].dry,
                    directed_rows[i].has_exp, directed_rows[i].wet_out);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      for (int s = 0; s < SEGMENTS; s++) begin
        wait_drained();
        random_settings();
        for (int n = 0; n < SEG_SAMPLES; n++) begin
          send_sample(CH_W'($urandom_range(CHANNELS - 1)), rand_sample(), 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (expected_out.size() != 0) begin
      note_error($sformatf("%0d predicted samples never arrived", expected_out.size()));
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
